/* design/ipx_pkg.sv */
// shared types and constants of the indexed pixel expander
package ipx_pkg;

  // field widths
  localparam int unsigned AddrW   = 12;
  localparam int unsigned EntryW  = 24;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned IndexW  = 12;
  localparam int unsigned WidthW  = 13;
  localparam int unsigned CompW   = 3;
  localparam int unsigned BpiW    = 2;
  localparam int unsigned PadW    = 2;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 13;

  // stream payload widths, padded to whole bytes
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 32;

  // item kinds carried in in_tuser
  localparam logic MODE_PALETTE = 1'b0;
  localparam logic MODE_PIXELS  = 1'b1;

  // index size codes
  localparam logic [BpiW-1:0] BPI_4  = 2'd0;
  localparam logic [BpiW-1:0] BPI_8  = 2'd1;
  localparam logic [BpiW-1:0] BPI_12 = 2'd2;

  // 12-bit unpack phases
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_BITS_PER_INDEX = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_IMAGE_WIDTH    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_PALETTE_COMP   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_HIGH_INDEX     = 2'd3;

  // entry layout: three components give color
  localparam logic [CompW-1:0] COLOR_COMPONENTS = 3'd3;

  // greatest row width the width register can express
  localparam int unsigned WidthRegMax = 8191;

  // per-pixel side information following a palette read
  typedef struct packed {
    logic            row_end;
    logic [PadW-1:0] pad_bytes;
    logic            last_of_item;
    logic            replicate;
  } pix_meta_t;

  // one finished pixel
  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
    logic             row_end;
    logic [PadW-1:0]  pad_bytes;
    logic             last_of_item;
  } pix_out_t;

endpackage

/* design/indexed_pixel_expander.sv */
// top level: packed palette index stream to 24-bit bgr pixels
//
//  channel | dir | handshake            | contents
//  --------+-----+----------------------+------------------------------------------
//  in_     | in  | in_tvalid/in_tready  | palette write or packed index byte
//  out_    | out | out_tvalid/out_tready| one bgr pixel with row end and padding
//  cfg_    | in  | cfg_we               | index size, width, components, high index
//
// a pixel passes issue, palette read and the output queue in that order. one
// pixel is issued per cycle while the queue has room; an 8-bit or 12-bit byte
// gives at most one pixel, a 4-bit byte up to two (both nibbles share the one
// read port). the palette memory needs no clearing pass; reset clears unpack
// state, counters, registers and the queue. a stall on out_ fills the two-entry
// queue, then holds in_tready low; an issued read always finds a queue slot.
module indexed_pixel_expander
  import ipx_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = 4096,
  parameter int unsigned MAX_WIDTH     = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [InDataW-1:0]   in_tdata,   // palette_address, palette_entry, data_byte
  input  logic                 in_tlast,   // last_byte
  input  logic                 in_tuser,   // mode
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OutDataW-1:0]  out_tdata,  // blue, green, red, pad_bytes
  output logic                 out_tlast,  // row_end
  output logic                 out_tuser,  // last_of_item
  // configuration
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  localparam int unsigned AW = $clog2(PALETTE_DEPTH);
  localparam logic [IndexW:0] MaxIdx = (IndexW+1)'(PALETTE_DEPTH - 1);
  localparam logic [AddrW:0]  DepthLim = (AddrW+1)'(PALETTE_DEPTH);
  localparam logic [WidthW:0] MaxW =
    (WidthW+1)'((MAX_WIDTH > WidthRegMax) ? WidthRegMax : MAX_WIDTH);

  // input fields
  logic [AddrW-1:0]  in_addr;
  logic [EntryW-1:0] in_entry;
  logic [ByteW-1:0]  in_byte;

  assign in_addr  = in_tdata[AddrW-1:0];
  assign in_entry = in_tdata[AddrW+EntryW-1:AddrW];
  assign in_byte  = in_tdata[AddrW+EntryW+ByteW-1:AddrW+EntryW];

  // configuration registers
  logic [BpiW-1:0]   bpi_r;
  logic [WidthW-1:0] width_r;
  logic [CompW-1:0]  comp_r;
  logic [IndexW-1:0] high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpi_r   <= BPI_8;
      width_r <= WidthW'(1);
      comp_r  <= COLOR_COMPONENTS;
      high_r  <= IndexW'(255);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BITS_PER_INDEX: bpi_r   <= cfg_data[BpiW-1:0];
        REG_IMAGE_WIDTH:    width_r <= cfg_data[WidthW-1:0];
        REG_PALETTE_COMP:   comp_r  <= cfg_data[CompW-1:0];
        REG_HIGH_INDEX:     high_r  <= cfg_data[IndexW-1:0];
        default: ;
      endcase
    end
  end

  // effective row width and the padding its byte stride needs
  logic [WidthW-1:0] w_eff;
  logic [1:0]        w3_mod4;
  logic [PadW-1:0]   row_pad;

  always_comb begin
    if (width_r == '0) begin
      w_eff = WidthW'(1);
    end else if ({1'b0, width_r} > MaxW) begin
      w_eff = MaxW[WidthW-1:0];
    end else begin
      w_eff = width_r;
    end
    w3_mod4 = 2'(w_eff[1:0] + {w_eff[0], 1'b0});
    row_pad = 2'(2'd0 - w3_mod4);
  end

  // unpack state
  logic [ByteW-1:0]  held_r, held_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [WidthW-1:0] col_r, col_nxt;
  logic              pend_r, pend_nxt;
  logic [3:0]        pend_nib_r, pend_nib_nxt;
  logic              pend_last_r, pend_last_nxt;

  // issue stage
  logic              out_fire, in_fire;
  logic              can_issue;
  logic [2:0]        occ;
  logic [1:0]        q_count;
  logic              issue;
  logic [IndexW-1:0] idx;
  logic              lof;
  logic              clr;
  logic [WidthW-1:0] col_inc;
  logic              row_done;
  logic [IndexW-1:0] idx_hi;
  logic [AW-1:0]     rd_addr;
  logic              ram_we;

  // side information travels beside the read
  logic              p1_valid_r;
  pix_meta_t         p1_meta_r;

  // a read may go out when its data will surely find a queue slot
  assign occ       = 3'({1'b0, q_count} + {2'b0, p1_valid_r});
  assign can_issue = (occ <= 3'd1) || (out_fire && (occ == 3'd2));
  assign in_tready = !pend_r && can_issue;
  assign in_fire   = in_tvalid && in_tready;

  assign col_inc  = WidthW'(col_r + 1'b1);
  assign row_done = (col_inc >= w_eff);

  always_comb begin
    issue         = 1'b0;
    idx           = '0;
    lof           = 1'b0;
    clr           = 1'b0;
    held_nxt      = held_r;
    phase_nxt     = phase_r;
    pend_nxt      = pend_r;
    pend_nib_nxt  = pend_nib_r;
    pend_last_nxt = pend_last_r;

    if (pend_r) begin
      // second nibble of a 4-bit byte
      if (can_issue) begin
        issue    = 1'b1;
        idx      = IndexW'(pend_nib_r);
        lof      = 1'b1;
        pend_nxt = 1'b0;
        clr      = pend_last_r;
      end
    end else if (in_fire && (in_tuser == MODE_PIXELS)) begin
      unique case (bpi_r)
        BPI_4: begin
          issue = 1'b1;
          idx   = IndexW'(in_byte[7:4]);
          lof   = row_done;
          if (row_done) begin
            clr = in_tlast;
          end else begin
            pend_nxt      = 1'b1;
            pend_nib_nxt  = in_byte[3:0];
            pend_last_nxt = in_tlast;
          end
        end
        BPI_12: begin
          unique case (phase_r)
            PH_FIRST: begin
              held_nxt  = in_byte;
              phase_nxt = PH_SECOND;
            end
            PH_SECOND: begin
              issue = 1'b1;
              lof   = 1'b1;
              idx   = {held_r, in_byte[7:4]};
              if (row_done) begin
                held_nxt  = '0;
                phase_nxt = PH_FIRST;
              end else begin
                held_nxt  = in_byte;
                phase_nxt = PH_THIRD;
              end
            end
            default: begin
              issue     = 1'b1;
              lof       = 1'b1;
              idx       = {held_r[3:0], in_byte};
              held_nxt  = '0;
              phase_nxt = PH_FIRST;
            end
          endcase
          clr = in_tlast;
        end
        default: begin
          issue = 1'b1;
          lof   = 1'b1;
          idx   = IndexW'(in_byte);
          clr   = in_tlast;
        end
      endcase
    end

    col_nxt = col_r;
    if (issue) begin
      col_nxt = row_done ? '0 : col_inc;
    end
    // end of image drops any partial index
    if (clr) begin
      held_nxt  = '0;
      phase_nxt = PH_FIRST;
      col_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      phase_r     <= PH_FIRST;
      col_r       <= '0;
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
    end else begin
      held_r      <= held_nxt;
      phase_r     <= phase_nxt;
      col_r       <= col_nxt;
      pend_r      <= pend_nxt;
      pend_last_r <= pend_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_nib_r <= pend_nib_nxt;
  end

  // clamp to the high index, then to the store
  always_comb begin
    idx_hi  = (idx > high_r) ? high_r : idx;
    rd_addr = ({1'b0, idx_hi} > MaxIdx) ? MaxIdx[AW-1:0] : idx_hi[AW-1:0];
  end

  assign ram_we = in_fire && (in_tuser == MODE_PALETTE) && ({1'b0, in_addr} < DepthLim);

  logic [EntryW-1:0] rd_data;

  ipx_palette_ram #(
    .DEPTH (PALETTE_DEPTH),
    .AW    (AW)
  ) u_palette (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (in_addr[AW-1:0]),
    .wr_data (in_entry),
    .rd_en   (issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p1_meta_r.row_end      <= row_done;
      p1_meta_r.pad_bytes    <= row_done ? row_pad : '0;
      p1_meta_r.last_of_item <= lof;
      p1_meta_r.replicate    <= (comp_r != COLOR_COMPONENTS);
    end
  end

  // entry to pixel: color entries are stored red first
  pix_out_t push_item;

  always_comb begin
    if (p1_meta_r.replicate) begin
      push_item.blue  = rd_data[23:16];
      push_item.green = rd_data[23:16];
      push_item.red   = rd_data[23:16];
    end else begin
      push_item.blue  = rd_data[7:0];
      push_item.green = rd_data[15:8];
      push_item.red   = rd_data[23:16];
    end
    push_item.row_end      = p1_meta_r.row_end;
    push_item.pad_bytes    = p1_meta_r.pad_bytes;
    push_item.last_of_item = p1_meta_r.last_of_item;
  end

  pix_out_t head_item;
  logic     head_valid;

  ipx_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (p1_valid_r),
    .push_item  (push_item),
    .pop        (out_tready),
    .head_valid (head_valid),
    .head_item  (head_item),
    .count      (q_count)
  );

  assign out_fire   = head_valid && out_tready;
  assign out_tvalid = head_valid;
  assign out_tdata  = {6'b0, head_item.pad_bytes, head_item.red,
                       head_item.green, head_item.blue};
  assign out_tlast  = head_item.row_end;
  assign out_tuser  = head_item.last_of_item;

endmodule

/* design/ipx_palette_ram.sv */
// palette memory: one write port, one registered read port
module ipx_palette_ram
  import ipx_pkg::*;
#(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [EntryW-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [EntryW-1:0] rd_data
);

  logic [EntryW-1:0] mem [DEPTH];
  logic [EntryW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/ipx_out_queue.sv */
// two-entry output queue between palette read and the result stream
module ipx_out_queue
  import ipx_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  pix_out_t push_item,
  input  logic     pop,
  output logic     head_valid,
  output pix_out_t head_item,
  output logic [1:0] count
);

  pix_out_t   slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_pop;

  assign do_pop = pop && (count_r != 2'd0);

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = 2'(count_r + {1'b0, push} - {1'b0, do_pop});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_valid = (count_r != 2'd0);
  assign head_item  = slot_r[rd_ptr_r];
  assign count      = count_r;

endmodule

/* verif/tb_indexed_pixel_expander.sv */
// self-checking testbench for the indexed pixel expander stream block
`timescale 1ns / 1ps

module tb_indexed_pixel_expander;
  import ipx_pkg::*;

  localparam int unsigned PaletteDepth = 4096;
  localparam int unsigned MaxWidth     = 4096;
  // palette entries loaded up front; 12-bit phases keep the high index below this
  localparam int unsigned FillDepth    = 256;
  // generous cycle budget, far above the slowest legal run
  localparam int unsigned CycleLimit   = 500000;
  // pipeline is three deep, give it some slack before touching registers
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned PhaseItems   = 125;
  localparam int unsigned NumPhases    = 10;

  // position inside a 12-bit index pair
  typedef enum logic [1:0] {
    UNPACK_IDLE,
    UNPACK_HIGH,
    UNPACK_LOW
  } unpack_phase_e;

  // predicts the bgr pixels produced by each accepted transfer and checks them
  class palette_pixel_model;
    logic [EntryW-1:0]  palette [PaletteDepth];
    logic [BpiW-1:0]    bits_code;
    logic [WidthW-1:0]  row_width;
    logic [CompW-1:0]   components;
    logic [IndexW-1:0]  top_index;
    logic [ByteW-1:0]   held;
    unpack_phase_e      phase;
    int                 column;
    pix_out_t           expected_pixels [$];
    int                 errors;

    function new();
      bits_code  = BPI_8;
      row_width  = 1;
      components = COLOR_COMPONENTS;
      top_index  = 255;
      held       = '0;
      phase      = UNPACK_IDLE;
      column     = 0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        REG_BITS_PER_INDEX: bits_code  = val[BpiW-1:0];
        REG_IMAGE_WIDTH:    row_width  = val[WidthW-1:0];
        REG_PALETTE_COMP:   components = val[CompW-1:0];
        REG_HIGH_INDEX:     top_index  = val[IndexW-1:0];
        default: ;
      endcase
    endfunction

    // one palette lookup; returns 1 when the pixel closes the row
    function bit make_pixel(logic [IndexW-1:0] index, output pix_out_t px);
      logic [EntryW-1:0] e;
      int                w;
      int                stride;
      bit                row_done;
      // a 12-bit index never exceeds the store, so only the high index clamps
      if (index > top_index) index = top_index;
      e = palette[index];
      if (components == COLOR_COMPONENTS) begin
        px.blue  = e[7:0];
        px.green = e[15:8];
        px.red   = e[23:16];
      end else begin
        px.blue  = e[23:16];
        px.green = e[23:16];
        px.red   = e[23:16];
      end
      w = (row_width == 0) ? 1 : ((row_width > MaxWidth) ? MaxWidth : int'(row_width));
      column++;
      row_done        = (column >= w);
      px.row_end      = row_done;
      px.pad_bytes    = '0;
      px.last_of_item = 1'b0;
      if (row_done) begin
        // rows are padded to a 4-byte stride
        stride       = ((w * 24 + 31) & ~31) >> 3;
        px.pad_bytes = PadW'((stride - 3 * w) & 3);
        column       = 0;
      end
      return row_done;
    endfunction

    function void note_input(logic mode, logic [AddrW-1:0] addr, logic [EntryW-1:0] entry,
                             logic [ByteW-1:0] data, logic last);
      pix_out_t px [2];
      int       n;
      n = 0;
      // palette writes leave unpacking and counters alone, last is ignored
      if (mode == MODE_PALETTE) begin
        palette[addr] = entry;
        return;
      end
      case (bits_code)
        BPI_4: begin
          n = 1;
          // second nibble is dropped when the first one ends the row
          if (!make_pixel(IndexW'(data[7:4]), px[0])) begin
            void'(make_pixel(IndexW'(data[3:0]), px[1]));
            n = 2;
          end
        end
        BPI_12: begin
          case (phase)
            UNPACK_IDLE: begin
              held  = data;
              phase = UNPACK_HIGH;
            end
            UNPACK_HIGH: begin
              n = 1;
              if (make_pixel({held, data[7:4]}, px[0])) begin
                phase = UNPACK_IDLE;
                held  = '0;
              end else begin
                held  = data;
                phase = UNPACK_LOW;
              end
            end
            default: begin
              n = 1;
              void'(make_pixel({held[3:0], data}, px[0]));
              phase = UNPACK_IDLE;
              held  = '0;
            end
          endcase
        end
        // 8-bit indices, code 3 behaves the same
        default: begin
          n = 1;
          void'(make_pixel(IndexW'(data), px[0]));
        end
      endcase
      if (n > 0) begin
        px[n-1].last_of_item = 1'b1;
        for (int i = 0; i < n; i++) expected_pixels.push_back(px[i]);
      end
      if (last) begin
        held   = '0;
        phase  = UNPACK_IDLE;
        column = 0;
      end
    endfunction

    function void check_pixel(pix_out_t got);
      pix_out_t want;
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: pixel with nothing pending: b=%02h g=%02h r=%02h end=%0b pad=%0d last=%0b",
                 $time, got.blue, got.green, got.red, got.row_end, got.pad_bytes,
                 got.last_of_item);
        return;
      end
      want = expected_pixels.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: pixel mismatch expected b=%02h g=%02h r=%02h end=%0b pad=%0d last=%0b",
                 $time, want.blue, want.green, want.red, want.row_end, want.pad_bytes,
                 want.last_of_item);
        $display("%0t:                actual   b=%02h g=%02h r=%02h end=%0b pad=%0d last=%0b",
                 $time, got.blue, got.green, got.red, got.row_end, got.pad_bytes,
                 got.last_of_item);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;
  logic                in_tlast;
  logic                in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tlast;
  logic                out_tuser;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  palette_pixel_model pixels = new();

  // idle and stall odds in percent, changed per phase
  int unsigned send_idle_pct  = 0;
  int unsigned out_stall_pct  = 0;
  int unsigned cycle_count    = 0;

  indexed_pixel_expander #(
    .PALETTE_DEPTH (PaletteDepth),
    .MAX_WIDTH     (MaxWidth)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_indexed_pixel_expander: errors");
      $finish;
    end
  end

  // result side: check each pixel transfer, then pick the next ready level
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        // out_tdata holds blue, green, red, pad_bytes from bit 0 up
        pixels.check_pixel('{blue:         out_tdata[7:0],
                             green:        out_tdata[15:8],
                             red:          out_tdata[23:16],
                             row_end:      out_tlast,
                             pad_bytes:    out_tdata[25:24],
                             last_of_item: out_tuser});
      end
      out_tready <= ($urandom_range(0, 99) >= out_stall_pct);
    end
  end

  // one input transfer; tvalid stays high afterwards so back-to-back items need
  // no second assignment in the same step
  task automatic push_item(input logic mode, input logic [AddrW-1:0] addr,
                           input logic [EntryW-1:0] entry, input logic [ByteW-1:0] data,
                           input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tlast  <= last;
    // in_tdata: palette_address, palette_entry, data_byte from bit 0 up
    in_tdata  <= {4'b0000, data, entry, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pixels.note_input(mode, addr, entry, data, last);
  endtask

  // image byte with random filler in the unused fields
  task automatic push_byte(input logic [ByteW-1:0] data, input logic last);
    push_item(MODE_PIXELS, AddrW'($urandom()), EntryW'($urandom()), data, last);
  endtask

  // random traffic: mostly image bytes, some palette writes, rare image ends
  task automatic push_random_item();
    if ($urandom_range(0, 99) < 10)
      push_item(MODE_PALETTE, AddrW'($urandom()), EntryW'($urandom()), ByteW'($urandom()),
                1'($urandom()));
    else
      push_byte(ByteW'($urandom()), $urandom_range(0, 99) < 4);
  endtask

  // stop sending and wait until every predicted pixel has been seen
  task automatic wait_quiet(input int unsigned settle);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pixels.expected_pixels.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // drain, then write all four registers back to back
  task automatic configure(input logic [CfgDataW-1:0] bpi, input logic [CfgDataW-1:0] width,
                           input logic [CfgDataW-1:0] comps, input logic [CfgDataW-1:0] high);
    logic [CfgIdxW-1:0]  regs [4];
    logic [CfgDataW-1:0] vals [4];
    regs = '{REG_BITS_PER_INDEX, REG_IMAGE_WIDTH, REG_PALETTE_COMP, REG_HIGH_INDEX};
    vals = '{bpi, width, comps, high};
    wait_quiet(SettleCycles);
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      pixels.write_reg(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // register sets of the random phases: index code, width, components, high index
  logic [CfgDataW-1:0] phase_cfg [NumPhases][4];

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tlast   <= 1'b0;
    in_tuser   <= MODE_PALETTE;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_BITS_PER_INDEX;
    cfg_data   <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the low palette entries; 4-bit and 8-bit indices never reach past them
    // and 12-bit phases clamp below them, so no lookup hits an unwritten entry
    for (int a = 0; a < FillDepth; a++) begin
      push_item(MODE_PALETTE, AddrW'(a),
                (a == 0) ? '0 : ((a == FillDepth - 1) ? '1 : EntryW'($urandom())),
                ByteW'($urandom()), 1'($urandom()));
    end

    // directed: reset settings, 8-bit indices at the extremes, one image end
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b1);

    // 4-bit indices, odd width so a row ends mid-byte, replicated component
    configure(BPI_4, 3, 1, 4095);
    push_byte(8'hF0, 1'b0);
    push_byte(8'h0F, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h3C, 1'b0);
    push_byte(8'h5A, 1'b1);

    // 12-bit indices clamped to a low high index, palette write inside a pair
    // with its last flag set, image end on a first piece
    configure(BPI_12, 2, COLOR_COMPONENTS, 100);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hF0, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'hAB, 1'b0);
    push_item(MODE_PALETTE, 12'd7, 24'h123456, 8'hFF, 1'b1);
    push_byte(8'hCD, 1'b0);
    push_byte(8'h77, 1'b0);
    push_byte(8'h55, 1'b1);

    // 12-bit with width one: each row ends inside a pair
    configure(BPI_12, 1, 0, 255);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'h56, 1'b0);
    push_byte(8'h78, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);

    // size code 3, width zero, odd component count, everything clamps to entry 0
    configure(2'd3, 0, 7, 0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b1);

    // random phases, extremes first, the last two drawn at random
    phase_cfg[0] = '{BPI_4,  1,    COLOR_COMPONENTS, 4095};
    phase_cfg[1] = '{BPI_8,  4096, 1,                4095};
    phase_cfg[2] = '{BPI_12, 3,    COLOR_COMPONENTS, 255};
    phase_cfg[3] = '{BPI_4,  5,    2,                9};
    phase_cfg[4] = '{BPI_12, 8191, 4,                0};
    phase_cfg[5] = '{BPI_8,  7,    COLOR_COMPONENTS, 200};
    phase_cfg[6] = '{BPI_12, 1,    0,                200};
    phase_cfg[7] = '{2'd3,   2,    COLOR_COMPONENTS, 4095};
    for (int p = 8; p < NumPhases; p++) begin
      phase_cfg[p][0] = CfgDataW'($urandom_range(0, 3));
      phase_cfg[p][1] = CfgDataW'($urandom_range(1, 12));
      phase_cfg[p][2] = CfgDataW'($urandom_range(0, 7));
      // 12-bit indices stay inside the filled entries
      phase_cfg[p][3] = (phase_cfg[p][0] == CfgDataW'(BPI_12)) ?
                        CfgDataW'($urandom_range(0, FillDepth - 1)) :
                        CfgDataW'($urandom_range(0, 4095));
    end

    for (int p = 0; p < NumPhases; p++) begin
      configure(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3]);
      // rotate through no idling, sender gaps, receiver stalls, and light both
      case (p % 4)
        0: begin send_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin send_idle_pct = 69; out_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  out_stall_pct = 69; end
        default: begin send_idle_pct = 12; out_stall_pct = 12; end
      endcase
      for (int k = 0; k < PhaseItems; k++) begin
        // sender holds off mid-phase until the pipeline has fully emptied
        if (p == 2 && k == PhaseItems / 2) wait_quiet(0);
        push_random_item();
      end
    end

    wait_quiet(SettleCycles + 2);
    if (pixels.errors == 0) begin
      $display("tb_indexed_pixel_expander: clean");
    end else begin
      $display("tb_indexed_pixel_expander: errors");
    end
    $finish;
  end

endmodule
